>>> sv/mmcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared constants and controller/datapath interface types for the
// min/max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    // Frame store depth and derived widths.
    localparam int MAX_PIXELS = 32768;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 16;

    // Reset value of the frame size register.
    localparam logic [CFG_W-1:0] PIXEL_COUNT_RESET = CFG_W'(19200);

    // Brightest grey level, also the full-scale output value.
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // The quotient has as many bits as a pixel, one bit per divider step.
    localparam int DIV_STEPS  = PIX_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic fetch_en;
        logic div_start;
        logic div_step;
        logic result_load;
    } mmcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_full;
        logic bypass;
        logic div_done;
        logic out_free;
    } mmcs_status_t;

endpackage

>>> sv/mmcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Controller state machine: accepts transactions and sequences the frame
// store read, the divider and the result write.
// ----------------------------------------------------------------------------
module mmcs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  command,
    output logic                  in_stall,
    input  mmcs_pkg::mmcs_status_t status,
    output mmcs_pkg::mmcs_cmd_t   cmd
);
    import mmcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (command == CMD_LOAD)
                    begin
                        cmd.load_en = 1'b1;
                    end
                    else if (status.frame_full)
                    begin
                        cmd.fetch_en = 1'b1;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.div_start = 1'b1;
                state_next    = status.bypass ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/mmcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcs_datapath
// Frame store, frame statistics, counters, a bit-serial divider and the
// output register.
// ----------------------------------------------------------------------------
module mmcs_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mmcs_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic [mmcs_pkg::PIX_W-1:0]  pixel,
    input  mmcs_pkg::mmcs_cmd_t         cmd,
    output mmcs_pkg::mmcs_status_t      status,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mmcs_pkg::PIX_W-1:0]  pixel_out,
    output logic                        last_pixel
);
    import mmcs_pkg::*;

    logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];

    logic [CFG_W-1:0]   pixel_count_reg;
    logic [PIX_W-1:0]   darkest_reg;
    logic [PIX_W-1:0]   brightest_reg;
    logic [CNT_W-1:0]   loaded_count_reg;
    logic [CNT_W-1:0]   drained_count_reg;
    logic               out_valid_reg;

    logic [PIX_W-1:0]   rd_data_reg;
    logic               last_reg;
    logic [PIX_W-1:0]   quot_reg;
    logic [PIX_W-1:0]   rem_reg;
    logic [PIX_W-1:0]   num_lo_reg;
    logic [PIX_W-1:0]   den_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [PIX_W-1:0]   pixel_out_reg;
    logic               last_pixel_reg;

    logic [CNT_W-1:0]   frame_n;
    logic               frame_full;
    logic               load_write;
    logic               last_next;
    logic [PIX_W-1:0]   diff;
    logic [2*PIX_W-1:0] num;
    logic               bypass;
    logic [PIX_W-1:0]   bypass_value;
    logic [PIX_W:0]     trial;
    logic               trial_ge;

    // Frame size: zero counts as one, and the store depth caps it.
    always_comb
    begin
        if (pixel_count_reg == '0)
        begin
            frame_n = CNT_W'(1);
        end
        else if (32'(pixel_count_reg) > MAX_PIXELS)
        begin
            frame_n = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            frame_n = CNT_W'(pixel_count_reg);
        end
    end

    assign frame_full = (loaded_count_reg >= frame_n);
    assign load_write = cmd.load_en && !frame_full;
    assign last_next  = (({1'b0, drained_count_reg} + (CNT_W + 1)'(1))
                         >= {1'b0, frame_n});

    // Special cases that need no division.
    assign bypass = (brightest_reg <= darkest_reg) || (rd_data_reg <= darkest_reg)
                    || (rd_data_reg >= brightest_reg);

    always_comb
    begin
        if (brightest_reg <= darkest_reg)
        begin
            bypass_value = rd_data_reg;
        end
        else if (rd_data_reg <= darkest_reg)
        begin
            bypass_value = '0;
        end
        else
        begin
            bypass_value = PIX_MAX;
        end
    end

    // (p - lo) * 255 as (d << 8) - d.
    assign diff = rd_data_reg - darkest_reg;
    assign num  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};

    // One restoring division step. The remainder stays below the divisor.
    assign trial    = {rem_reg, num_lo_reg[PIX_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            frame_mem[loaded_count_reg[ADDR_W-1:0]] <= pixel;
        end
        if (cmd.fetch_en)
        begin
            rd_data_reg <= frame_mem[drained_count_reg[ADDR_W-1:0]];
        end
    end

    // Divider and payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.fetch_en)
        begin
            last_reg <= last_next;
        end
        if (cmd.div_start)
        begin
            quot_reg   <= bypass ? bypass_value : '0;
            rem_reg    <= num[2*PIX_W-1:PIX_W];
            num_lo_reg <= num[PIX_W-1:0];
            den_reg    <= brightest_reg - darkest_reg;
        end
        else if (cmd.div_step)
        begin
            quot_reg   <= {quot_reg[PIX_W-2:0], trial_ge};
            rem_reg    <= trial_ge ? PIX_W'(trial - {1'b0, den_reg}) : trial[PIX_W-1:0];
            num_lo_reg <= {num_lo_reg[PIX_W-2:0], 1'b0};
        end
        if (cmd.result_load)
        begin
            pixel_out_reg  <= quot_reg;
            last_pixel_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg   <= PIXEL_COUNT_RESET;
            darkest_reg       <= PIX_MAX;
            brightest_reg     <= '0;
            loaded_count_reg  <= '0;
            drained_count_reg <= '0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pixel_count_reg <= cfg_wr_data;
            end

            if (load_write)
            begin
                loaded_count_reg <= loaded_count_reg + CNT_W'(1);
                if (pixel < darkest_reg)
                begin
                    darkest_reg <= pixel;
                end
                if (pixel > brightest_reg)
                begin
                    brightest_reg <= pixel;
                end
            end

            if (cmd.div_start)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    darkest_reg       <= PIX_MAX;
                    brightest_reg     <= '0;
                    loaded_count_reg  <= '0;
                    drained_count_reg <= '0;
                end
                else
                begin
                    drained_count_reg <= drained_count_reg + CNT_W'(1);
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.frame_full = frame_full;
    assign status.bypass     = bypass;
    assign status.div_done   = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign last_pixel = last_pixel_reg;

endmodule

>>> sv/min_max_contrast_stretch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_top
// Min/max contrast stretch over one frame of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// A load transaction (command 0) writes one pixel into the 32768-entry frame
// store and updates the running darkest and brightest values; while no drain
// is in progress, loads can stream at one per clock and give no result. Once
// the frame holds pixel_count pixels, each drain transaction (command 1)
// returns the next stored pixel in load order, stretched to 0..255 against
// the frame's darkest and brightest values, with last_pixel set on the final
// one, after which the statistics and counters start over for a new frame.
// A drain that needs a division goes through these steps before the next
// transaction can be taken: acceptance, which also reads the frame store,
// the load of the divider, the bit-serial divider (one quotient bit per
// cycle) and the write of the output register. Pixels at or beyond the
// frame's extremes, and frames with no spread, skip the divider. A drain
// that arrives before the frame is full, and a load into a full frame, are
// dropped. The output register lets a new transaction be accepted while the
// previous result still waits downstream; a finished result only waits
// there if that register is still occupied.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration: frame size in pixels.
    input  logic                        cfg_wr_en,
    input  logic [mmcs_pkg::CFG_W-1:0]  cfg_wr_data,
    // Input channel.
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [mmcs_pkg::PIX_W-1:0]  pixel,
    // Output channel.
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mmcs_pkg::PIX_W-1:0]  pixel_out,
    output logic                        last_pixel
);
    import mmcs_pkg::*;

    mmcs_cmd_t    cmd;
    mmcs_status_t status;

    // The controller owns the handshake on the input side and sequences
    // every drain of a full frame through the datapath.
    mmcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds all data storage and owns the output register.
    mmcs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pixel       (pixel),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel)
    );

endmodule

>>> sv/mmcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcs_checker
// Port-level checks for the min/max contrast stretch block, bound to the
// top level.
// ----------------------------------------------------------------------------
module mmcs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        command,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [mmcs_pkg::PIX_W-1:0]  pixel_out,
    input logic                        last_pixel
);
    import mmcs_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(last_pixel))
        else $error("output payload changed while stalled");

    // A load never makes the block busy.
    a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_LOAD) |=> !in_stall)
        else $error("block stalled after a load transaction");

    // A fresh result appears only at the end of a busy drain.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a drain in progress");

    // When a drain finishes the block hands over its result.
    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("drain finished without a result");

endmodule

bind min_max_contrast_stretch_top mmcs_checker u_mmcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .last_pixel (last_pixel)
);

>>> dv/min_max_contrast_stretch_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_top_test
// Self-checking bench for the min/max contrast stretch block: frames of grey
// pixels are loaded and drained under random handshake pressure, and every
// stretched pixel is compared against a cycle-free prediction of the block.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_top_test;

    import mmcs_pkg::*;

    // Idle pause long enough for any transaction still in flight to finish,
    // a drain through the divider included.
    localparam int SETTLE_CYCLES  = 16;
    // Longest correct quiet stretch is roughly a receiver stall, a divider
    // pass, a sender gap and a settle pause; this is many times that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 400;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             is_last;
    } stretched_pixel_t;

    typedef enum {PIX_FULL, PIX_WINDOW, PIX_FLAT} pixel_mix_t;

    // Predicts the block transaction by transaction. Loads fill a private
    // frame copy and update the running extremes; each answered drain pushes
    // the stretched pixel it must produce onto expected_pixels.
    class stretch_predictor;
        logic [PIX_W-1:0] frame_pixels [MAX_PIXELS];
        logic [CFG_W-1:0] size_reg;
        int unsigned      darkest;
        int unsigned      brightest;
        int unsigned      loaded;
        int unsigned      drained;
        stretched_pixel_t expected_pixels [$];
        int unsigned      mismatches;
        int unsigned      loads_taken;
        int unsigned      pixels_checked;
        int unsigned      frames_done;

        function new();
            size_reg       = PIXEL_COUNT_RESET;
            mismatches     = 0;
            loads_taken    = 0;
            pixels_checked = 0;
            frames_done    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            darkest   = 255;
            brightest = 0;
            loaded    = 0;
            drained   = 0;
        endfunction

        // A size of zero means one pixel; anything past the store saturates.
        function int unsigned frame_size();
            if (size_reg == '0)
                return 1;
            if (32'(size_reg) > MAX_PIXELS)
                return MAX_PIXELS;
            return 32'(size_reg);
        endfunction

        function void set_size(logic [CFG_W-1:0] size);
            size_reg = size;
        endfunction

        // Returns 1 when the transaction changed the block's state.
        function bit note_input(logic cmd, logic [PIX_W-1:0] pix);
            int unsigned      n;
            int unsigned      p;
            int unsigned      value;
            stretched_pixel_t item;
            n = frame_size();
            if (cmd == CMD_LOAD)
            begin
                if (loaded >= n)
                    return 1'b0;
                frame_pixels[loaded] = pix;
                loaded++;
                if (32'(pix) < darkest)
                    darkest = 32'(pix);
                if (32'(pix) > brightest)
                    brightest = 32'(pix);
                loads_taken++;
                return 1'b1;
            end
            if (loaded < n)
                return 1'b0;
            p = 32'(frame_pixels[drained]);
            if (brightest <= darkest)
                value = p;
            else if (p <= darkest)
                value = 0;
            else if (p >= brightest)
                value = 255;
            else
                value = ((p - darkest) * 255) / (brightest - darkest);
            item.value   = value[PIX_W-1:0];
            item.is_last = (drained + 1 >= n);
            expected_pixels.push_back(item);
            if (item.is_last)
            begin
                clear_frame();
                frames_done++;
            end
            else
            begin
                drained++;
            end
            return 1'b1;
        endfunction

        function void check_result(logic [PIX_W-1:0] value, logic is_last);
            stretched_pixel_t item;
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %0d last_pixel %0b", value, is_last);
                mismatches++;
                return;
            end
            item = expected_pixels.pop_front();
            pixels_checked++;
            if (value !== item.value)
            begin
                $error("pixel_out: expected %0d, actual %0d", item.value, value);
                mismatches++;
            end
            if (is_last !== item.is_last)
            begin
                $error("last_pixel: expected %0b, actual %0b", item.is_last, is_last);
                mismatches++;
            end
        endfunction

        function bit all_clean();
            if (expected_pixels.size() != 0)
            begin
                $error("%0d stretched pixels never arrived", expected_pixels.size());
                return 1'b0;
            end
            return (mismatches == 0);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic             command;
    logic [PIX_W-1:0] pixel;
    logic             out_valid;
    logic             out_stall;
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;

    stretch_predictor predictor = new();

    int unsigned burst_left   = 0;
    int unsigned useful_items = 0;
    int unsigned size_writes  = 0;
    int unsigned quiet_cycles = 0;
    pixel_mix_t  pix_mix      = PIX_FULL;
    int unsigned win_lo       = 0;
    int unsigned win_hi       = 255;

    min_max_contrast_stretch_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: stall on its own rhythm of free runs and stall runs.
    // Free runs are now and then long so that whole frames drain unhindered,
    // and stall runs are now and then long enough to back up the block.
    initial
    begin : receiver
        int unsigned run_len;
        logic        hold;
        out_stall = 1'b0;
        hold      = 1'b0;
        forever
        begin
            if (hold)
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16)
                                                      : $urandom_range(1, 4);
            else
                run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
            repeat (run_len)
            begin
                @(negedge clk);
                out_stall <= hold;
            end
            hold = !hold;
        end
    end

    // Every result transaction is checked at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            predictor.check_result(pixel_out, last_pixel);
    end

    // The run is stopped if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("min_max_contrast_stretch_top_test NOT OK");
            $finish;
        end
    end

    // Pixel values follow the mix chosen for the current phase: the full range
    // or a random window (spread anywhere from none to wide), with 0 or 255 now
    // and then, or one flat level, which leaves the frame without spread.
    function automatic logic [PIX_W-1:0] next_pixel();
        if (pix_mix == PIX_FLAT)
            return win_lo[PIX_W-1:0];
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? PIX_MAX : '0;
        if (pix_mix == PIX_WINDOW)
            return PIX_W'($urandom_range(win_lo, win_hi));
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Sends one input transaction, starting and ending at a falling edge.
    // The sender works in bursts; between bursts it drops valid for a gap,
    // which is sometimes zero so that bursts run back to back.
    task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        command  <= cmd;
        pixel    <= pix;
        do
            @(posedge clk);
        while (in_stall);
        if (predictor.note_input(cmd, pix))
            useful_items++;
        @(negedge clk);
    endtask

    // Lets the block run dry: every expected pixel has come back, and loads
    // or dropped transactions behind the last one have had time to finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (predictor.expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The frame size is only rewritten with the block idle; a partly loaded
    // or partly drained frame stays in place and sees the new size at once.
    task automatic reconfigure(input logic [CFG_W-1:0] size);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        predictor.set_size(size);
        size_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned      target;
        int unsigned      steps;
        int unsigned      pick;
        logic [CFG_W-1:0] size;
        logic             cmd;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        command     = CMD_LOAD;
        pixel       = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. A drain into an empty frame at the reset size is
        // dropped. Five loads then sit in a 19200-pixel frame, and shrinking
        // the size to three makes it full with the last two pixels dropped;
        // their values still count toward the extremes.
        send_item(CMD_DRAIN, 8'd0);
        send_item(CMD_LOAD, 8'd100);
        send_item(CMD_LOAD, 8'd50);
        send_item(CMD_LOAD, 8'd200);
        send_item(CMD_LOAD, 8'd128);
        send_item(CMD_LOAD, 8'd255);
        reconfigure(16'd3);
        // A load into the full frame must not pull the darkest value down.
        send_item(CMD_LOAD, 8'd0);
        repeat (3) send_item(CMD_DRAIN, 8'd0);

        // Size zero behaves as a one-pixel frame: no spread, pixel unchanged.
        reconfigure(16'd0);
        send_item(CMD_LOAD, 8'd77);
        send_item(CMD_DRAIN, 8'd0);
        send_item(CMD_LOAD, 8'd0);
        send_item(CMD_DRAIN, 8'd0);

        // Full-scale spread: every pixel maps onto itself, extremes included.
        reconfigure(16'd4);
        send_item(CMD_LOAD, 8'd0);
        send_item(CMD_LOAD, 8'd255);
        send_item(CMD_LOAD, 8'd1);
        send_item(CMD_LOAD, 8'd254);
        repeat (4) send_item(CMD_DRAIN, 8'd0);

        // Growing the size mid-frame asks for more loads before draining.
        reconfigure(16'd2);
        send_item(CMD_LOAD, 8'd10);
        reconfigure(16'd3);
        send_item(CMD_LOAD, 8'd20);
        send_item(CMD_LOAD, 8'd30);
        repeat (3) send_item(CMD_DRAIN, 8'd0);

        // Random part. Each phase picks a size and a pixel mix, then mostly
        // follows the frame: loads until full, drains until the frame ends,
        // with a few out-of-turn transactions as noise. Phases end at random
        // points, so many size changes land in the middle of a frame.
        target = useful_items + RANDOM_ITEMS;
        while (useful_items < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                size = '0;
            else if (pick == 1)
                size = 16'd1;
            else if (pick == 2)
                size = CFG_W'($urandom_range(49, 65535));
            else if (pick < 5)
                size = CFG_W'($urandom_range(13, 48));
            else
                size = CFG_W'($urandom_range(2, 12));
            reconfigure(size);
            pix_mix = pixel_mix_t'($urandom_range(0, 2));
            win_lo  = $urandom_range(0, 255);
            win_hi  = $urandom_range(win_lo, 255);
            steps   = $urandom_range(4, 60);
            repeat (steps)
            begin
                pick = $urandom_range(0, 99);
                if (predictor.loaded < predictor.frame_size())
                    cmd = (pick < 8) ? CMD_DRAIN : CMD_LOAD;
                else
                    cmd = (pick < 8) ? CMD_LOAD : CMD_DRAIN;
                send_item(cmd, next_pixel());
            end
        end

        // Largest setting: 65535 saturates to the store depth, so a short
        // frame stays open and its drains are dropped. Shrinking the size
        // below the load count then makes the frame full at once, a further
        // load is dropped, and the frame drains to its end.
        reconfigure(16'hFFFF);
        pix_mix = PIX_WINDOW;
        win_lo  = 20;
        win_hi  = 230;
        send_item(CMD_DRAIN, 8'd0);
        repeat (24) send_item(CMD_LOAD, next_pixel());
        send_item(CMD_DRAIN, 8'd0);
        reconfigure(16'd6);
        send_item(CMD_LOAD, 8'd0);
        repeat (6) send_item(CMD_DRAIN, 8'd0);

        settle();
        $display("Covered %0d accepted loads and %0d stretched pixels in %0d whole frames,",
                 predictor.loads_taken, predictor.pixels_checked, predictor.frames_done);
        $display("across %0d frame-size writes including zero, one and the saturating maximum.",
                 size_writes);
        if (predictor.all_clean())
            $display("min_max_contrast_stretch_top_test OK");
        else
            $display("min_max_contrast_stretch_top_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
sv/mmcs_pkg.sv
sv/mmcs_ctrl.sv
sv/mmcs_datapath.sv
sv/min_max_contrast_stretch_top.sv
sv/mmcs_checker.sv
dv/min_max_contrast_stretch_top_test.sv
